// File: hdl/nprr_pkg.sv
// Shared types and codes of the note press/release recorder.
package nprr_pkg;

  // Input word kinds
  typedef enum logic [1:0] {
    KIND_START   = 2'd0,
    KIND_PRESS   = 2'd1,
    KIND_RELEASE = 2'd2,
    KIND_STOP    = 2'd3
  } kind_t;

  // Result word operations
  typedef enum logic [2:0] {
    OP_START_TIME    = 3'd0,
    OP_APPEND_OFFSET = 3'd1,
    OP_NEW_ENTRY     = 3'd2,
    OP_SET_RELEASE   = 3'd3,
    OP_STOPPED       = 3'd4,
    OP_HELD_FULL     = 3'd5
  } op_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SEARCH,
    ST_SHIFT,
    ST_STOP
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic latch;
    logic do_start;
    logic do_press;
    logic scan;
    logic shift_wr;
    logic dec_held;
    logic stop_clr;
    logic emit;
    op_t  op;
    logic last;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    kind_t kind;
    logic  recording;
    logic  active;
    logic  held_full;
    logic  pattern_full;
    logic  existing_zero;
    logic  match;
    logic  pend;
    logic  scan_done;
  } status_t;

endpackage

// File: hdl/nprr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module nprr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: hdl/nprr_ctrl.sv
// Sequencing state machine of the note press/release recorder.
module nprr_ctrl
  import nprr_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  output logic    busy,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.op    = OP_START_TIME;
    busy      = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_nxt = ST_IDLE;
        case (status.kind)
          KIND_START: begin
            cmd.do_start = 1'b1;
            cmd.emit     = 1'b1;
            cmd.last     = 1'b1;
            cmd.op       = status.existing_zero ? OP_START_TIME : OP_APPEND_OFFSET;
          end
          KIND_PRESS: begin
            if (status.recording) begin
              if (status.held_full) begin
                cmd.emit = 1'b1;
                cmd.last = 1'b1;
                cmd.op   = OP_HELD_FULL;
              end else if (!status.pattern_full) begin
                cmd.do_press = 1'b1;
                cmd.emit     = 1'b1;
                cmd.last     = 1'b1;
                cmd.op       = OP_NEW_ENTRY;
              end
            end
          end
          KIND_RELEASE: begin
            if (status.recording) begin
              state_nxt = ST_SEARCH;
            end
          end
          KIND_STOP: begin
            if (status.active) begin
              state_nxt = ST_STOP;
            end
          end
          default: state_nxt = ST_IDLE;
        endcase
      end
      ST_SEARCH: begin
        // Walk held entries oldest first until the pitch matches
        cmd.scan = 1'b1;
        if (status.match) begin
          cmd.emit  = 1'b1;
          cmd.last  = 1'b1;
          cmd.op    = OP_SET_RELEASE;
          state_nxt = ST_SHIFT;
        end else if (status.scan_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SHIFT: begin
        // Close the gap left by the released entry
        cmd.scan     = 1'b1;
        cmd.shift_wr = 1'b1;
        if (status.scan_done) begin
          cmd.dec_held = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_STOP: begin
        // Release every held entry, then report stopped
        cmd.scan = 1'b1;
        if (status.pend) begin
          cmd.emit = 1'b1;
          cmd.op   = OP_SET_RELEASE;
        end else if (status.scan_done) begin
          cmd.emit     = 1'b1;
          cmd.last     = 1'b1;
          cmd.op       = OP_STOPPED;
          cmd.stop_clr = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// File: hdl/nprr_dpath.sv
// Datapath of the note press/release recorder: state, held table and result register.
module nprr_dpath
  import nprr_pkg::*;
#(
  parameter int PATTERN_DEPTH = 256,
  parameter int MAX_HELD = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output status_t     status,
  input  logic [1:0]  in_kind,
  input  logic [6:0]  in_pitch,
  input  logic [31:0] in_now,
  input  logic [8:0]  in_step_limit,
  input  logic [8:0]  in_existing_count,
  input  logic [31:0] in_existing_last_release,
  output logic        out_strobe,
  output logic [2:0]  out_op,
  output logic [7:0]  out_slot,
  output logic [6:0]  out_note_pitch,
  output logic [31:0] out_instant,
  output logic        out_last
);

  localparam int CW = $clog2(PATTERN_DEPTH + 1);
  localparam int SW = $clog2(PATTERN_DEPTH);
  localparam int HW = $clog2(MAX_HELD + 1);
  localparam int IW = (MAX_HELD > 1) ? $clog2(MAX_HELD) : 1;
  localparam int EW = SW + 7;

  // Latched input word
  kind_t       kind_r;
  logic [6:0]  pitch_r;
  logic [31:0] now_r;
  logic [8:0]  limit_in_r;
  logic [8:0]  existing_r;
  logic [31:0] last_rel_r;

  // Recorder state
  logic          active_r;
  logic [CW-1:0] entry_count_r;
  logic [8:0]    limit_r;
  logic [31:0]   offset_r;
  logic [HW-1:0] held_count_r;

  // Walk over the held table
  logic [HW-1:0] idx_r;
  logic [HW-1:0] pend_idx_r;
  logic [HW-1:0] shift_dst;
  logic          pend_r;
  logic          rd_issue;

  // Result register
  logic        strobe_r;
  op_t         op_r;
  logic [7:0]  slot_r;
  logic [6:0]  note_pitch_r;
  logic [31:0] instant_r;
  logic        last_r;
  logic [7:0]  slot_nxt;
  logic [6:0]  note_pitch_nxt;
  logic [31:0] instant_nxt;

  // Held table port signals
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [EW-1:0] wr_data;
  logic [EW-1:0] rd_data;
  logic [SW-1:0] rd_slot;
  logic [6:0]    rd_pitch;

  logic [CW-1:0] existing_clamped;
  logic [31:0]   occupancy;
  logic          recording;

  assign rd_slot  = rd_data[EW-1:7];
  assign rd_pitch = rd_data[6:0];

  // Clamp the existing count to the pattern depth
  assign existing_clamped = (32'(existing_r) > 32'(PATTERN_DEPTH)) ?
                            CW'(PATTERN_DEPTH) : CW'(existing_r);

  // Recording while started and below the step limit (a limit of zero means no limit)
  assign occupancy = 32'(entry_count_r) + 32'(held_count_r);
  assign recording = active_r && ((limit_r == 9'd0) || (occupancy < 32'(limit_r)));

  assign rd_issue  = cmd.scan && (idx_r < held_count_r);
  assign shift_dst = pend_idx_r - HW'(1);

  // Press appends at the top of the table; a shift moves one entry down
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = held_count_r[IW-1:0];
    wr_data = {entry_count_r[SW-1:0], pitch_r};
    if (cmd.do_press) begin
      wr_en = 1'b1;
    end else if (cmd.shift_wr && pend_r) begin
      wr_en   = 1'b1;
      wr_addr = shift_dst[IW-1:0];
      wr_data = rd_data;
    end
  end

  nprr_ram #(
    .WIDTH(EW),
    .DEPTH(MAX_HELD)
  ) u_held (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_issue),
    .rd_addr(idx_r[IW-1:0]),
    .rd_data(rd_data)
  );

  // Capture the input word
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      kind_r     <= kind_t'(in_kind);
      pitch_r    <= in_pitch;
      now_r      <= in_now;
      limit_in_r <= in_step_limit;
      existing_r <= in_existing_count;
      last_rel_r <= in_existing_last_release;
    end
  end

  // Recorder state updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r      <= 1'b0;
      entry_count_r <= '0;
      limit_r       <= '0;
      offset_r      <= '0;
      held_count_r  <= '0;
    end else begin
      if (cmd.do_start) begin
        active_r      <= 1'b1;
        entry_count_r <= existing_clamped;
        limit_r       <= limit_in_r;
        held_count_r  <= '0;
        offset_r      <= (existing_r == 9'd0) ? 32'd0 : now_r - last_rel_r;
      end
      if (cmd.do_press) begin
        held_count_r  <= held_count_r + HW'(1);
        entry_count_r <= entry_count_r + CW'(1);
      end
      if (cmd.dec_held) begin
        held_count_r <= held_count_r - HW'(1);
      end
      if (cmd.stop_clr) begin
        held_count_r <= '0;
        active_r     <= 1'b0;
      end
    end
  end

  // Advance the walk index and track read data in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= rd_issue && !cmd.latch;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      idx_r <= '0;
    end else if (rd_issue) begin
      idx_r <= idx_r + HW'(1);
    end
    pend_idx_r <= idx_r;
  end

  // Result word fields for the operation being emitted
  always_comb begin
    slot_nxt       = 8'd0;
    note_pitch_nxt = 7'd0;
    instant_nxt    = now_r;
    case (cmd.op)
      OP_APPEND_OFFSET: instant_nxt = now_r - last_rel_r;
      OP_NEW_ENTRY: begin
        slot_nxt       = 8'(entry_count_r);
        note_pitch_nxt = pitch_r;
        instant_nxt    = now_r - offset_r;
      end
      OP_SET_RELEASE: begin
        slot_nxt       = 8'(rd_slot);
        note_pitch_nxt = rd_pitch;
        // Stop releases at raw time
        instant_nxt    = (kind_r == KIND_STOP) ? now_r : now_r - offset_r;
      end
      OP_HELD_FULL: note_pitch_nxt = pitch_r;
      default: instant_nxt = now_r;
    endcase
  end

  // Result word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      op_r         <= cmd.op;
      last_r       <= cmd.last;
      slot_r       <= slot_nxt;
      note_pitch_r <= note_pitch_nxt;
      instant_r    <= instant_nxt;
    end
  end

  assign out_strobe     = strobe_r;
  assign out_op         = op_r;
  assign out_slot       = slot_r;
  assign out_note_pitch = note_pitch_r;
  assign out_instant    = instant_r;
  assign out_last       = last_r;

  // Status towards the controller
  always_comb begin
    status               = '0;
    status.kind          = kind_r;
    status.recording     = recording;
    status.active        = active_r;
    status.held_full     = (32'(held_count_r) >= 32'(MAX_HELD));
    status.pattern_full  = (32'(entry_count_r) >= 32'(PATTERN_DEPTH));
    status.existing_zero = (existing_r == 9'd0);
    status.match         = pend_r && (rd_pitch == pitch_r);
    status.pend          = pend_r;
    status.scan_done     = !pend_r && (idx_r >= held_count_r);
  end

endmodule

// File: hdl/note_press_release_recorder_top.sv
// Top level of the note press/release recorder.
//
//  channel   handshake                 payload
//  input     start / busy              in_kind, in_pitch, in_now, in_step_limit,
//                                      in_existing_count, in_existing_last_release
//  result    out_strobe (one cycle)    out_op, out_slot, out_note_pitch,
//                                      out_instant, out_last
//
// A word is taken when start is high and busy is low; results are registered
// and follow in the cycle after the controller produces them. A release walks the
// held table one entry a cycle and, on a pitch match, then closes the gap; a stop
// walks it too, releasing every held entry. The held table RAM has a single read
// port, so each walk reads one entry at a time.
// Reset is synchronous, active low; the held table needs no clearing.
// Results cannot be stalled: out_strobe marks each result for one cycle.
module note_press_release_recorder_top
  import nprr_pkg::*;
#(
  parameter int PATTERN_DEPTH = 256,
  parameter int MAX_HELD = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_kind,
  input  logic [6:0]  in_pitch,
  input  logic [31:0] in_now,
  input  logic [8:0]  in_step_limit,
  input  logic [8:0]  in_existing_count,
  input  logic [31:0] in_existing_last_release,
  output logic        out_strobe,
  output logic [2:0]  out_op,
  output logic [7:0]  out_slot,
  output logic [6:0]  out_note_pitch,
  output logic [31:0] out_instant,
  output logic        out_last
);

  cmd_t    cmd;
  status_t status;

  nprr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .status(status),
    .cmd   (cmd)
  );

  nprr_dpath #(
    .PATTERN_DEPTH(PATTERN_DEPTH),
    .MAX_HELD     (MAX_HELD)
  ) u_dpath (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cmd                     (cmd),
    .status                  (status),
    .in_kind                 (in_kind),
    .in_pitch                (in_pitch),
    .in_now                  (in_now),
    .in_step_limit           (in_step_limit),
    .in_existing_count       (in_existing_count),
    .in_existing_last_release(in_existing_last_release),
    .out_strobe              (out_strobe),
    .out_op                  (out_op),
    .out_slot                (out_slot),
    .out_note_pitch          (out_note_pitch),
    .out_instant             (out_instant),
    .out_last                (out_last)
  );

endmodule
